// File: rtl/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the sorted table bound search core: request
// codes, fixed field widths and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package sbs_pkg;

  // fixed widths of the request and response fields
  localparam int unsigned REQ_TYPE_W    = 2;
  localparam int unsigned ENTRY_INDEX_W = 10;
  localparam int unsigned KEY_IN_W      = 32;
  localparam int unsigned RANGE_START_W = 10;
  localparam int unsigned RANGE_END_W   = 11;
  localparam int unsigned MATCH_INDEX_W = 10;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_WRITE     = 2'd0,
    REQ_LEFTMOST  = 2'd1,
    REQ_RIGHTMOST = 2'd2,
    REQ_FLOOR     = 2'd3
  } req_type_e;

  // which position the table read port looks at
  typedef enum logic [1:0] {
    RD_START   = 2'd0,
    RD_MID     = 2'd1,
    RD_LEFT    = 2'd2,
    RD_LEFT_M1 = 2'd3
  } rd_sel_e;

  typedef struct packed {
    logic    wr_entry;   // store the request key into the table
    logic    load;       // capture a query request
    logic    rd_en;      // read the table at rd_sel
    rd_sel_e rd_sel;
    logic    step;       // narrow the window using the last read key
    logic    set_res;    // latch the pending result
    logic    res_hit;
    logic    res_at_left; // result index is left, else left - 1
    logic    push;       // move pending result to the response register
  } ctl_cmd_t;

  typedef struct packed {
    req_type_e mode;
    logic      empty;        // start not below saturated end
    logic      left_lt_right;
    logic      left_eq_start;
    logic      left_eq_end;
    logic      key_lt_data;  // search key below the last read key
    logic      key_eq_data;
    logic      out_free;     // response register can take a result
  } ctl_sts_t;

endpackage

// File: rtl/sbs_req_if.sv
// ----------------------------------------------------------------------------
// sbs_req_if
// Request channel: table writes and bound search queries.
// ----------------------------------------------------------------------------
interface sbs_req_if;
  import sbs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_TYPE_W-1:0]    req_type;
  logic [ENTRY_INDEX_W-1:0] entry_index;
  logic [KEY_IN_W-1:0]      entry_key;
  logic [KEY_IN_W-1:0]      search_key;
  logic [RANGE_START_W-1:0] range_start;
  logic [RANGE_END_W-1:0]   range_end;

  modport source (
    output valid, req_type, entry_index, entry_key, search_key, range_start, range_end,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, entry_key, search_key, range_start, range_end,
    output ready
  );

endinterface

// File: rtl/sbs_rsp_if.sv
// ----------------------------------------------------------------------------
// sbs_rsp_if
// Response channel: found flag and matching index of one query.
// ----------------------------------------------------------------------------
interface sbs_rsp_if;
  import sbs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [MATCH_INDEX_W-1:0] match_index;

  modport source (
    output valid, found, match_index,
    input  ready
  );

  modport sink (
    input  valid, found, match_index,
    output ready
  );

endinterface

// File: rtl/sbs_ctrl.sv
// ----------------------------------------------------------------------------
// sbs_ctrl
// Query sequencer: accepts requests, steps the binary search one probe at a
// time and hands the result to the response register.
// ----------------------------------------------------------------------------
module sbs_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  input  logic [sbs_pkg::REQ_TYPE_W-1:0]   req_type_i,
  output logic                             req_ready_o,
  input  sbs_pkg::ctl_sts_t                sts_i,
  output sbs_pkg::ctl_cmd_t                cmd_o
);
  import sbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PRE,
    ST_PROBE,
    ST_STEP,
    ST_FIN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_MID;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_type_e'(req_type_i) == REQ_WRITE) begin
            cmd_o.wr_entry = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (sts_i.empty) begin
          cmd_o.set_res = 1'b1;
          state_d       = ST_DONE;
        end else if (sts_i.mode == REQ_FLOOR) begin
          // floor first checks the key at the range start
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_START;
          state_d      = ST_PRE;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_PRE: begin
        if (sts_i.key_lt_data) begin
          cmd_o.set_res = 1'b1;
          state_d       = ST_DONE;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (sts_i.left_lt_right) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_MID;
          state_d      = ST_STEP;
        end else begin
          case (sts_i.mode)
            REQ_LEFTMOST: begin
              if (sts_i.left_eq_end) begin
                cmd_o.set_res = 1'b1;
                state_d       = ST_DONE;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RD_LEFT;
                state_d      = ST_FIN;
              end
            end
            REQ_RIGHTMOST: begin
              if (sts_i.left_eq_start) begin
                cmd_o.set_res = 1'b1;
                state_d       = ST_DONE;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RD_LEFT_M1;
                state_d      = ST_FIN;
              end
            end
            REQ_FLOOR: begin
              cmd_o.set_res     = 1'b1;
              cmd_o.res_hit     = !sts_i.left_eq_start;
              cmd_o.res_at_left = 1'b0;
              state_d           = ST_DONE;
            end
            default: begin
              cmd_o.set_res = 1'b1;
              state_d       = ST_DONE;
            end
          endcase
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_PROBE;
      end
      ST_FIN: begin
        cmd_o.set_res     = 1'b1;
        cmd_o.res_hit     = sts_i.key_eq_data;
        cmd_o.res_at_left = (sts_i.mode == REQ_LEFTMOST);
        state_d           = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/sbs_datapath.sv
// ----------------------------------------------------------------------------
// sbs_datapath
// Key table memory, search window registers, comparators and the result
// and response registers.
// ----------------------------------------------------------------------------
module sbs_datapath #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sbs_pkg::REQ_TYPE_W-1:0]      req_type_i,
  input  logic [sbs_pkg::ENTRY_INDEX_W-1:0]   entry_index_i,
  input  logic [sbs_pkg::KEY_IN_W-1:0]        entry_key_i,
  input  logic [sbs_pkg::KEY_IN_W-1:0]        search_key_i,
  input  logic [sbs_pkg::RANGE_START_W-1:0]   range_start_i,
  input  logic [sbs_pkg::RANGE_END_W-1:0]     range_end_i,
  input  sbs_pkg::ctl_cmd_t                   cmd_i,
  output sbs_pkg::ctl_sts_t                   sts_o,
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  output logic                                rsp_found_o,
  output logic [sbs_pkg::MATCH_INDEX_W-1:0]   rsp_match_index_o
);
  import sbs_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  // positions must hold the table depth itself and any range end
  localparam int unsigned PW = (IDX_W + 1 > RANGE_END_W) ? IDX_W + 1 : RANGE_END_W;
  localparam logic [PW-1:0] DEPTH_POS = PW'(TABLE_DEPTH);

  logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];

  req_type_e            mode_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] rdata_q;
  logic [PW-1:0]        start_q, end_q, left_q, right_q;
  logic                 res_found_q;
  logic [PW-1:0]        res_pos_q;
  logic                 out_valid_q;
  logic                 out_found_q;
  logic [MATCH_INDEX_W-1:0] out_idx_q;

  logic [63:0]          entry_key_ext, search_key_ext;
  logic [PW-1:0]        wr_pos, end_pos, end_sat, mid, rd_pos, res_pos;
  logic                 go_right;

  assign entry_key_ext  = 64'(entry_key_i);
  assign search_key_ext = 64'(search_key_i);
  assign wr_pos         = PW'(entry_index_i);
  assign end_pos        = PW'(range_end_i);
  assign end_sat        = (end_pos > DEPTH_POS) ? DEPTH_POS : end_pos;
  assign mid            = left_q + ((right_q - left_q) >> 1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_START:   rd_pos = start_q;
      RD_MID:     rd_pos = mid;
      RD_LEFT:    rd_pos = left_q;
      RD_LEFT_M1: rd_pos = left_q - PW'(1);
      default:    rd_pos = mid;
    endcase
  end

  // leftmost moves right only past strictly smaller keys
  assign go_right = (mode_q == REQ_LEFTMOST) ? (key_q > rdata_q) : (key_q >= rdata_q);
  assign res_pos  = cmd_i.res_at_left ? left_q : left_q - PW'(1);

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry && (wr_pos < DEPTH_POS)) begin
      key_mem[wr_pos[IDX_W-1:0]] <= entry_key_ext[KEY_WIDTH-1:0];
    end
    if (cmd_i.rd_en) begin
      rdata_q <= key_mem[rd_pos[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= req_type_e'(req_type_i);
      key_q   <= search_key_ext[KEY_WIDTH-1:0];
      start_q <= PW'(range_start_i);
      end_q   <= end_sat;
      left_q  <= PW'(range_start_i);
      right_q <= end_sat;
    end else if (cmd_i.step) begin
      if (go_right) begin
        left_q <= mid + PW'(1);
      end else begin
        right_q <= mid;
      end
    end
    if (cmd_i.set_res) begin
      res_found_q <= cmd_i.res_hit;
      res_pos_q   <= cmd_i.res_hit ? res_pos : '0;
    end
    if (cmd_i.push) begin
      out_found_q <= res_found_q;
      out_idx_q   <= res_pos_q[MATCH_INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.mode          = mode_q;
  assign sts_o.empty         = (start_q >= end_q);
  assign sts_o.left_lt_right = (left_q < right_q);
  assign sts_o.left_eq_start = (left_q == start_q);
  assign sts_o.left_eq_end   = (left_q == end_q);
  assign sts_o.key_lt_data   = (key_q < rdata_q);
  assign sts_o.key_eq_data   = (key_q == rdata_q);
  assign sts_o.out_free      = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o       = out_valid_q;
  assign rsp_found_o       = out_found_q;
  assign rsp_match_index_o = out_idx_q;

endmodule

// File: rtl/sorted_table_bound_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_bound_search_core
// Binary search over a table of keys kept in ascending order.
// ----------------------------------------------------------------------------
// A write request stores one key. A query request (first
// match, last match or floor over the range [range_start, range_end)) runs a
// binary search through the single read port of the key table, whose read
// data is registered: every probe sets the read address in ST_PROBE and
// compares the registered read data in ST_STEP. One query is in flight at a
// time; the response register lets the next request in while a result waits
// to be taken. Table contents are undefined after reset, so a query must
// only probe written entries.
// ----------------------------------------------------------------------------
module sorted_table_bound_search_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbs_req_if.sink    req_i,
  sbs_rsp_if.source  rsp_o
);
  import sbs_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  sbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_type_i        (req_i.req_type),
    .entry_index_i     (req_i.entry_index),
    .entry_key_i       (req_i.entry_key),
    .search_key_i      (req_i.search_key),
    .range_start_i     (req_i.range_start),
    .range_end_i       (req_i.range_end),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_found_o       (rsp_o.found),
    .rsp_match_index_o (rsp_o.match_index)
  );

  // a result never overwrites one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response overwritten before it was taken");

  // a query request blocks further requests while it runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_type_e'(req_i.req_type) != REQ_WRITE))
      |=> !req_i.ready)
    else $error("request taken during a running query");

  // a response only appears after a result was pushed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.push))
    else $error("response valid without a finished query");

  // a miss always reports index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.found) |-> (rsp_o.match_index == '0))
    else $error("miss with nonzero index");

endmodule
